[hw/rtl/mma_pkg.sv]
// Shared types, codes and the operation schedule of the matrix accumulator.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int unsigned REQ_BITS = 2;
  localparam int unsigned IDX_BITS = 4;
  localparam int unsigned STEP_BITS = 6;
  localparam int unsigned CNT_BITS = 7;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_ROTATE    = 2'd1,
    REQ_SCALE     = 2'd2,
    REQ_TRANSFORM = 2'd3
  } req_t;

  // Multiplier operand sources and result destinations.
  typedef enum logic [1:0] {
    SRC_OPND = 2'd0,  // latched item operand
    SRC_MAT  = 2'd1,  // stored matrix entry
    SRC_ROT  = 2'd2   // rotation matrix entry built from quaternion products
  } src_t;

  typedef enum logic [1:0] {
    DST_QP  = 2'd0,  // quaternion product register
    DST_NEW = 2'd1,  // new matrix buffer
    DST_MAT = 2'd2,  // stored matrix entry
    DST_OUT = 2'd3   // result vector element
  } dst_t;

  typedef struct packed {
    src_t                a_src;
    logic [IDX_BITS-1:0] a_idx;
    src_t                b_src;
    logic [IDX_BITS-1:0] b_idx;
    dst_t                dst;
    logic [IDX_BITS-1:0] d_idx;
    logic                first;
    logic                last;
  } op_t;

  typedef struct packed {
    logic load;       // latch operands, clear results and flag
    logic issue;      // op is valid this cycle
    op_t  op;
    logic translate;  // add operands into column 3
    logic commit;     // copy new matrix buffer into the stored matrix
  } cmd_t;

  typedef struct packed {
    logic busy;       // multiply pipeline holds work
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_FINISH = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  localparam int unsigned QP_COUNT = 9;

  // Quaternion products: ii jj kk ij ik jk wi wj wk (i=0 j=1 k=2 w=3).
  localparam logic [1:0] QP_A [QP_COUNT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1, 2'd3, 2'd3, 2'd3};
  localparam logic [1:0] QP_B [QP_COUNT] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2};

  function automatic logic [CNT_BITS-1:0] op_count(input req_t req, input logic rot_phase);
    logic [CNT_BITS-1:0] n;
    unique case (req)
      REQ_TRANSLATE: n = CNT_BITS'(0);
      REQ_ROTATE:    n = rot_phase ? CNT_BITS'(64) : CNT_BITS'(QP_COUNT);
      REQ_SCALE:     n = CNT_BITS'(3);
      REQ_TRANSFORM: n = CNT_BITS'(16);
      default:       n = CNT_BITS'(0);
    endcase
    return n;
  endfunction

  function automatic op_t op_decode(input req_t req, input logic rot_phase,
                                    input logic [STEP_BITS-1:0] step);
    op_t o;
    logic [3:0] qs;
    o = '0;
    qs = step[3:0];
    unique case (req)
      REQ_ROTATE: begin
        if (!rot_phase) begin
          o.a_src = SRC_OPND;
          o.a_idx = {2'b00, QP_A[qs]};
          o.b_src = SRC_OPND;
          o.b_idx = {2'b00, QP_B[qs]};
          o.dst   = DST_QP;
          o.d_idx = qs;
          o.first = 1'b1;
          o.last  = 1'b1;
        end else begin
          // step = {m, n, k}: new[m][n] += rot[m][k] * mat[k][n]
          o.a_src = SRC_ROT;
          o.a_idx = {step[5:4], step[1:0]};
          o.b_src = SRC_MAT;
          o.b_idx = {step[1:0], step[3:2]};
          o.dst   = DST_NEW;
          o.d_idx = step[5:2];
          o.first = (step[1:0] == 2'd0);
          o.last  = (step[1:0] == 2'd3);
        end
      end
      REQ_SCALE: begin
        o.a_src = SRC_MAT;
        o.a_idx = {step[1:0], step[1:0]};
        o.b_src = SRC_OPND;
        o.b_idx = {2'b00, step[1:0]};
        o.dst   = DST_MAT;
        o.d_idx = {step[1:0], step[1:0]};
        o.first = 1'b1;
        o.last  = 1'b1;
      end
      REQ_TRANSFORM: begin
        o.a_src = SRC_MAT;
        o.a_idx = step[3:0];
        o.b_src = SRC_OPND;
        o.b_idx = {2'b00, step[1:0]};
        o.dst   = DST_OUT;
        o.d_idx = {2'b00, step[3:2]};
        o.first = (step[1:0] == 2'd0);
        o.last  = (step[1:0] == 2'd3);
      end
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

[hw/rtl/mma_if.sv]
// Item channel interfaces: request channel and result channel.
`timescale 1ns / 1ps
interface mma_in_if #(parameter int unsigned WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic signed [WORD_BITS-1:0] operand_a;
  logic signed [WORD_BITS-1:0] operand_b;
  logic signed [WORD_BITS-1:0] operand_c;
  logic signed [WORD_BITS-1:0] operand_d;

  modport source (output valid, req_type, operand_a, operand_b, operand_c, operand_d,
                  input ready);
  modport sink (input valid, req_type, operand_a, operand_b, operand_c, operand_d,
                output ready);
endinterface

interface mma_out_if #(parameter int unsigned WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] out_x;
  logic signed [WORD_BITS-1:0] out_y;
  logic signed [WORD_BITS-1:0] out_z;
  logic signed [WORD_BITS-1:0] out_w;
  logic                        saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

[hw/rtl/mma_datapath.sv]
// Datapath: matrix store, rotation builder, shared multiplier and accumulator.
`timescale 1ns / 1ps
module mma_datapath #(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mma_pkg::cmd_t               cmd,
  output mma_pkg::stat_t              stat,
  input  logic signed [WORD_BITS-1:0] in_a,
  input  logic signed [WORD_BITS-1:0] in_b,
  input  logic signed [WORD_BITS-1:0] in_c,
  input  logic signed [WORD_BITS-1:0] in_d,
  output logic signed [WORD_BITS-1:0] res_x,
  output logic signed [WORD_BITS-1:0] res_y,
  output logic signed [WORD_BITS-1:0] res_z,
  output logic signed [WORD_BITS-1:0] res_w,
  output logic                        res_sat
);
  import mma_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned AW = WORD_BITS + 2;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_V = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  // Saturating add or subtract; returns {clipped, value}.
  function automatic logic [W:0] add_sat(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y, input logic sub);
    logic signed [W:0] s;
    logic ovf;
    s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
    ovf = s[W] ^ s[W-1];
    return {ovf, ovf ? (s[W] ? MINV : MAXV) : s[W-1:0]};
  endfunction

  logic signed [W-1:0] opnd [4];
  logic signed [W-1:0] mat [16];
  logic signed [W-1:0] nmat [16];
  logic signed [W-1:0] qp [QP_COUNT];
  logic signed [W-1:0] res [4];
  logic                sat_flag;

  // Rotation entries from the quaternion products.
  logic signed [W-1:0] rot [16];
  logic [15:0]         rot_ovf;

  always_comb begin
    logic [W:0] t;
    logic [W:0] u;
    logic [W:0] v;
    for (int e = 0; e < 16; e++) begin
      rot[e] = '0;
      rot_ovf[e] = 1'b0;
    end
    rot[15] = ONE_V;
    // diagonal: 1 - 2(p + q)
    t = add_sat(qp[1], qp[2], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    v = add_sat(ONE_V, u[W-1:0], 1'b1);
    rot[0] = v[W-1:0]; rot_ovf[0] = t[W] | u[W] | v[W];
    t = add_sat(qp[0], qp[2], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    v = add_sat(ONE_V, u[W-1:0], 1'b1);
    rot[5] = v[W-1:0]; rot_ovf[5] = t[W] | u[W] | v[W];
    t = add_sat(qp[0], qp[1], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    v = add_sat(ONE_V, u[W-1:0], 1'b1);
    rot[10] = v[W-1:0]; rot_ovf[10] = t[W] | u[W] | v[W];
    // off diagonal: 2(p +/- q)
    t = add_sat(qp[3], qp[8], 1'b1); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[1] = u[W-1:0]; rot_ovf[1] = t[W] | u[W];
    t = add_sat(qp[4], qp[7], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[2] = u[W-1:0]; rot_ovf[2] = t[W] | u[W];
    t = add_sat(qp[3], qp[8], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[4] = u[W-1:0]; rot_ovf[4] = t[W] | u[W];
    t = add_sat(qp[5], qp[6], 1'b1); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[6] = u[W-1:0]; rot_ovf[6] = t[W] | u[W];
    t = add_sat(qp[4], qp[7], 1'b1); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[8] = u[W-1:0]; rot_ovf[8] = t[W] | u[W];
    t = add_sat(qp[5], qp[6], 1'b0); u = add_sat(t[W-1:0], t[W-1:0], 1'b0);
    rot[9] = u[W-1:0]; rot_ovf[9] = t[W] | u[W];
  end

  // Operand select: one matrix read port, shared by whichever side needs it.
  logic [IDX_BITS-1:0] mat_addr;
  logic signed [W-1:0] mat_rd;
  logic signed [W-1:0] sel_a;
  logic signed [W-1:0] sel_b;
  logic                sel_ovf;

  assign mat_addr = (cmd.op.a_src == SRC_MAT) ? cmd.op.a_idx : cmd.op.b_idx;
  assign mat_rd   = mat[mat_addr];

  always_comb begin
    sel_ovf = 1'b0;
    unique case (cmd.op.a_src)
      SRC_MAT: sel_a = mat_rd;
      SRC_ROT: begin
        sel_a   = rot[cmd.op.a_idx];
        sel_ovf = rot_ovf[cmd.op.a_idx];
      end
      default: sel_a = opnd[cmd.op.a_idx[1:0]];
    endcase
    sel_b = (cmd.op.b_src == SRC_MAT) ? mat_rd : opnd[cmd.op.b_idx[1:0]];
  end

  // Stage 1: operands; stage 2: product; then truncate, clip and accumulate.
  logic                 v1, v2;
  op_t                  op1, op2;
  logic signed [W-1:0]  opa1, opb1;
  logic                 ovf1, ovf2;
  logic signed [PW-1:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
    op1  <= cmd.op;
    opa1 <= sel_a;
    opb1 <= sel_b;
    ovf1 <= cmd.issue & sel_ovf;
    op2  <= op1;
    ovf2 <= ovf1;
    prod2 <= opa1 * opb1;
  end

  assign stat.busy = v1 | v2;

  logic signed [PW-1:0] trunc;
  logic                 povf;
  logic signed [W-1:0]  psat;
  logic signed [AW-1:0] acc, acc_next;
  logic                 aovf;
  logic signed [W-1:0]  asat;

  always_comb begin
    trunc = prod2 >>> FRACTION_BITS;
    povf  = !((&trunc[PW-1:W-1]) || !(|trunc[PW-1:W-1]));
    psat  = povf ? (trunc[PW-1] ? MINV : MAXV) : trunc[W-1:0];
    acc_next = op2.first ? AW'(psat) : acc + AW'(psat);
    aovf  = !((&acc_next[AW-1:W-1]) || !(|acc_next[AW-1:W-1]));
    asat  = aovf ? (acc_next[AW-1] ? MINV : MAXV) : acc_next[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (v2) acc <= acc_next;
  end

  logic [W:0] tr0, tr1, tr2;
  assign tr0 = add_sat(mat[3], opnd[0], 1'b0);
  assign tr1 = add_sat(mat[7], opnd[1], 1'b0);
  assign tr2 = add_sat(mat[11], opnd[2], 1'b0);

  logic wr_last;
  assign wr_last = v2 & op2.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 16; e++) begin
        mat[e] <= (e % 5 == 0) ? ONE_V : '0;
      end
    end else if (cmd.commit) begin
      for (int e = 0; e < 16; e++) begin
        mat[e] <= nmat[e];
      end
    end else if (cmd.translate) begin
      mat[3]  <= tr0[W-1:0];
      mat[7]  <= tr1[W-1:0];
      mat[11] <= tr2[W-1:0];
    end else if (wr_last && op2.dst == DST_MAT) begin
      mat[op2.d_idx] <= asat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd[0] <= in_a;
      opnd[1] <= in_b;
      opnd[2] <= in_c;
      opnd[3] <= in_d;
    end
    if (wr_last && op2.dst == DST_NEW) nmat[op2.d_idx] <= asat;
    if (wr_last && op2.dst == DST_QP) qp[op2.d_idx] <= asat;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int e = 0; e < 4; e++) begin
        res[e] <= '0;
      end
      sat_flag <= 1'b0;
    end else begin
      if (wr_last && op2.dst == DST_OUT) res[op2.d_idx[1:0]] <= asat;
      if ((v2 && (povf || ovf2 || (op2.last && aovf))) ||
          (cmd.translate && (tr0[W] || tr1[W] || tr2[W]))) begin
        sat_flag <= 1'b1;
      end
    end
  end

  assign res_x   = res[0];
  assign res_y   = res[1];
  assign res_z   = res[2];
  assign res_w   = res[3];
  assign res_sat = sat_flag;

endmodule

[hw/rtl/mma_ctrl.sv]
// Controller: sequences the multiply operations of each request.
`timescale 1ns / 1ps
module mma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output mma_pkg::cmd_t  cmd,
  input  mma_pkg::stat_t stat
);
  import mma_pkg::*;

  state_t               state, state_next;
  req_t                 req;
  logic                 rot_phase;
  logic [STEP_BITS-1:0] step;
  logic [CNT_BITS-1:0]  count;

  assign count     = op_count(req, rot_phase);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && (state == S_IDLE);
    cmd.op        = op_decode(req, rot_phase, step);
    cmd.issue     = (state == S_ISSUE) && (count != '0);
    cmd.translate = (state == S_ISSUE) && (count == '0);
    cmd.commit    = (state == S_FINISH) && (req == REQ_ROTATE);
    state_next    = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_ISSUE;
      S_ISSUE:  if (count == '0 || CNT_BITS'(step) == count - 1'b1) state_next = S_DRAIN;
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = (req == REQ_ROTATE && !rot_phase) ? S_ISSUE : S_FINISH;
        end
      end
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      rot_phase <= 1'b0;
      req       <= REQ_TRANSLATE;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        req       <= req_t'(in_req);
        rot_phase <= 1'b0;
        step      <= '0;
      end else if (state == S_ISSUE) begin
        step <= step + 1'b1;
      end else if (state == S_DRAIN && !stat.busy) begin
        rot_phase <= 1'b1;
        step      <= '0;
      end
    end
  end

endmodule

[hw/rtl/model_matrix_accumulator_core.sv]
// Top level of the 4x4 transform matrix accumulator.
//
//   channel  dir  fields
//   in_ch    in   req_type, operand_a..operand_d (signed fixed point)
//   out_ch   out  out_x, out_y, out_z, out_w (signed fixed point), saturated
//
// One item at a time, all products through one shared multiplier with a
// three stage operand/product/accumulate pipe. A translate needs no
// products, a scale 3 and a transform 16; a rotate issues 9 quaternion
// products, drains the pipe, then issues 64 matrix products and drains.
// Reset loads the identity matrix; no clearing pass. A stalled result holds
// the block: the next item can be taken in the cycle after the result goes.
`timescale 1ns / 1ps
module model_matrix_accumulator_core #(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  mma_in_if.sink    in_ch,
  mma_out_if.source out_ch
);
  import mma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decides which product runs in each cycle.
  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (in_ch.req_type),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Matrix store and arithmetic; results stay stable while out_ch is stalled.
  mma_datapath #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_a    (in_ch.operand_a),
    .in_b    (in_ch.operand_b),
    .in_c    (in_ch.operand_c),
    .in_d    (in_ch.operand_d),
    .res_x   (out_ch.out_x),
    .res_y   (out_ch.out_y),
    .res_z   (out_ch.out_z),
    .res_w   (out_ch.out_w),
    .res_sat (out_ch.saturated)
  );

endmodule
